[rtl/pixel_blend_mode_compositor_top_defines.svh]
// Assertion macros shared by the compositor checker.
`ifndef PIXEL_BLEND_MODE_COMPOSITOR_TOP_DEFINES_SVH
`define PIXEL_BLEND_MODE_COMPOSITOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define PBMC_ASSERT_AT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define PBMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

[rtl/pbmc_pkg.sv]
// Shared types, codes and arithmetic helpers of the blend-mode compositor.
package pbmc_pkg;

    typedef logic [3:0] t_mode;

    localparam t_mode MODE_ALPHA     = 4'd0;
    localparam t_mode MODE_ADD       = 4'd1;
    localparam t_mode MODE_SUB       = 4'd2;
    localparam t_mode MODE_MUL       = 4'd3;
    localparam t_mode MODE_DIV       = 4'd4;
    localparam t_mode MODE_SCREEN    = 4'd5;
    localparam t_mode MODE_OVERLAY   = 4'd6;
    localparam t_mode MODE_DARKEN    = 4'd7;
    localparam t_mode MODE_LIGHTEN   = 4'd8;
    localparam t_mode MODE_HARDLIGHT = 4'd9;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_GAIN = 2'd1;

    localparam logic [7:0] MAX8  = 8'd255;
    localparam logic [7:0] HALF8 = 8'd128;

    typedef struct packed {
        logic [7:0] a;
        t_mode      mode;
        logic       pass_dst;
        logic       copy_src;
    } t_ctl;

    // floor(x / 255) by reciprocal estimate and one correction
    function automatic logic [8:0] div255(input logic [16:0] x);
        logic [24:0] e;
        logic [8:0]  q;
        logic [17:0] r;
        e = {x, 8'h00} + 25'(x);
        q = e[24:16];
        r = {1'b0, x} - {1'b0, q, 8'h00} + 18'(q);
        if (r >= 18'd255) begin
            q = q + 9'd1;
        end
        return q;
    endfunction

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nbit,
                                            input logic [7:0] dvs);
        logic [8:0] t;
        logic [8:0] diff;
        t    = {rem, nbit};
        diff = t - {1'b0, dvs};
        if (t >= {1'b0, dvs}) begin
            return {1'b1, diff[7:0]};
        end else begin
            return {1'b0, t[7:0]};
        end
    endfunction

endpackage

[rtl/pixel_blend_mode_compositor_top.sv]
// Top level of the RGBA8 blend-mode compositor: registers, opacity stage, lanes.
//
// Takes one destination and one source RGBA8 pixel per clock and returns the
// composited pixel on the o_out_* ports, with o_strobe high, once it has passed
// the registered opacity stage and the lane stages. busy stays low, so a pixel
// may be started in every cycle. The depth is set by the divide-mode quotient
// unit, which resolves two quotient bits per stage over four stages, followed
// by the mix multipliers and the final divide by 255. Each result is on the
// ports for one cycle only and the receiver must take it then. blend_mode and
// alpha_gain must be written through the i_cfg_* port only while no pixel is
// in flight; the block does not enforce this.
module pixel_blend_mode_compositor_top import pbmc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [7:0]            i_dst_red,
    input  logic [7:0]            i_dst_green,
    input  logic [7:0]            i_dst_blue,
    input  logic [7:0]            i_dst_alpha,
    input  logic [7:0]            i_src_red,
    input  logic [7:0]            i_src_green,
    input  logic [7:0]            i_src_blue,
    input  logic [7:0]            i_src_alpha,
    output logic                  o_strobe,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_blue,
    output logic [7:0]            o_out_alpha
);

    localparam int PIPE_DEPTH = 7;
    localparam logic [CFG_DATA_W-1:0] GAIN_RESET = 9'd256;

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    t_mode                 r_mode;
    logic [CFG_DATA_W-1:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ALPHA;
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLEND_MODE: r_mode <= i_cfg_data[3:0];
                CFG_ALPHA_GAIN: r_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: effective opacity and special-case flags
    logic [16:0] n_prod;
    logic [8:0]  n_a_raw;
    t_ctl        n_ctl;

    assign n_prod  = 17'(i_src_alpha) * 17'(r_gain);
    assign n_a_raw = n_prod[16:8];

    always_comb begin
        n_ctl.a        = n_a_raw[8] ? MAX8 : n_a_raw[7:0];
        n_ctl.mode     = (r_mode > MODE_HARDLIGHT) ? MODE_ALPHA : r_mode;
        n_ctl.pass_dst = (n_ctl.a == 8'd0);
        n_ctl.copy_src = (n_ctl.mode == MODE_ALPHA) && (n_ctl.a == MAX8);
    end

    t_ctl       r_ctl;
    logic [7:0] r_dst_red;
    logic [7:0] r_dst_green;
    logic [7:0] r_dst_blue;
    logic [7:0] r_dst_alpha;
    logic [7:0] r_src_red;
    logic [7:0] r_src_green;
    logic [7:0] r_src_blue;
    logic [7:0] r_src_alpha;

    always_ff @(posedge i_clk) begin
        r_ctl       <= n_ctl;
        r_dst_red   <= i_dst_red;
        r_dst_green <= i_dst_green;
        r_dst_blue  <= i_dst_blue;
        r_dst_alpha <= i_dst_alpha;
        r_src_red   <= i_src_red;
        r_src_green <= i_src_green;
        r_src_blue  <= i_src_blue;
        r_src_alpha <= i_src_alpha;
    end

    // valid bits, one per stage
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_vld;

    assign n_vld = {r_vld[PIPE_DEPTH-2:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    pbmc_lane u_lane_red (
        .i_clk (i_clk),
        .i_d   (r_dst_red),
        .i_s   (r_src_red),
        .i_ctl (r_ctl),
        .o_pix (o_out_red)
    );

    pbmc_lane u_lane_green (
        .i_clk (i_clk),
        .i_d   (r_dst_green),
        .i_s   (r_src_green),
        .i_ctl (r_ctl),
        .o_pix (o_out_green)
    );

    pbmc_lane u_lane_blue (
        .i_clk (i_clk),
        .i_d   (r_dst_blue),
        .i_s   (r_src_blue),
        .i_ctl (r_ctl),
        .o_pix (o_out_blue)
    );

    pbmc_alpha_lane u_lane_alpha (
        .i_clk   (i_clk),
        .i_d     (r_dst_alpha),
        .i_s     (r_src_alpha),
        .i_ctl   (r_ctl),
        .o_alpha (o_out_alpha)
    );

    assign o_strobe = r_vld[PIPE_DEPTH-1];

endmodule

[rtl/pbmc_lane.sv]
// One colour channel: blend-mode value, opacity mix and final select.
module pbmc_lane import pbmc_pkg::*; (
    input  logic       i_clk,
    input  logic [7:0] i_d,
    input  logic [7:0] i_s,
    input  t_ctl       i_ctl,
    output logic [7:0] o_pix
);

    // stage 2: products, first two quotient bits of 255*d/s
    logic [15:0] n_num;
    logic [8:0]  n_st7;
    logic [8:0]  n_st6;
    logic [15:0] r_s2_prod_ds;
    logic [15:0] r_s2_prod_inv;
    logic [7:0]  r_s2_rem;
    logic [1:0]  r_s2_q;
    logic [5:0]  r_s2_nlow;
    logic [7:0]  r_s2_d;
    logic [7:0]  r_s2_s;
    t_ctl        r_s2_ctl;

    assign n_num = {i_d, 8'h00} - {8'h00, i_d};
    assign n_st7 = div_step(n_num[15:8], n_num[7], i_s);
    assign n_st6 = div_step(n_st7[7:0], n_num[6], i_s);

    always_ff @(posedge i_clk) begin
        r_s2_prod_ds  <= 16'(i_d) * 16'(i_s);
        r_s2_prod_inv <= 16'(MAX8 - i_d) * 16'(MAX8 - i_s);
        r_s2_rem      <= n_st6[7:0];
        r_s2_q        <= {n_st7[8], n_st6[8]};
        r_s2_nlow     <= n_num[5:0];
        r_s2_d        <= i_d;
        r_s2_s        <= i_s;
        r_s2_ctl      <= i_ctl;
    end

    // stage 3: scaled products, quotient bits 5..4
    logic [8:0] n_q_mul;
    logic [8:0] n_q_scr;
    logic [8:0] n_q2_lo;
    logic [8:0] n_q2_hi;
    logic [8:0] n_st5;
    logic [8:0] n_st4;
    logic [7:0] r_s3_q_mul;
    logic [7:0] r_s3_q_scr;
    logic [7:0] r_s3_q2_lo;
    logic [7:0] r_s3_q2_hi;
    logic [7:0] r_s3_rem;
    logic [3:0] r_s3_q;
    logic [3:0] r_s3_nlow;
    logic [7:0] r_s3_d;
    logic [7:0] r_s3_s;
    t_ctl       r_s3_ctl;

    assign n_q_mul = div255({1'b0, r_s2_prod_ds});
    assign n_q_scr = div255({1'b0, r_s2_prod_inv});
    assign n_q2_lo = div255({r_s2_prod_ds, 1'b0});
    assign n_q2_hi = div255({r_s2_prod_inv, 1'b0});
    assign n_st5   = div_step(r_s2_rem, r_s2_nlow[5], r_s2_s);
    assign n_st4   = div_step(n_st5[7:0], r_s2_nlow[4], r_s2_s);

    always_ff @(posedge i_clk) begin
        r_s3_q_mul <= n_q_mul[7:0];
        r_s3_q_scr <= n_q_scr[7:0];
        r_s3_q2_lo <= n_q2_lo[7:0];
        r_s3_q2_hi <= n_q2_hi[7:0];
        r_s3_rem   <= n_st4[7:0];
        r_s3_q     <= {r_s2_q, n_st5[8], n_st4[8]};
        r_s3_nlow  <= r_s2_nlow[3:0];
        r_s3_d     <= r_s2_d;
        r_s3_s     <= r_s2_s;
        r_s3_ctl   <= r_s2_ctl;
    end

    // stage 4: quotient bits 3..2
    logic [8:0] n_st3;
    logic [8:0] n_st2;
    logic [7:0] r_s4_q_mul;
    logic [7:0] r_s4_q_scr;
    logic [7:0] r_s4_q2_lo;
    logic [7:0] r_s4_q2_hi;
    logic [7:0] r_s4_rem;
    logic [5:0] r_s4_q;
    logic [1:0] r_s4_nlow;
    logic [7:0] r_s4_d;
    logic [7:0] r_s4_s;
    t_ctl       r_s4_ctl;

    assign n_st3 = div_step(r_s3_rem, r_s3_nlow[3], r_s3_s);
    assign n_st2 = div_step(n_st3[7:0], r_s3_nlow[2], r_s3_s);

    always_ff @(posedge i_clk) begin
        r_s4_q_mul <= r_s3_q_mul;
        r_s4_q_scr <= r_s3_q_scr;
        r_s4_q2_lo <= r_s3_q2_lo;
        r_s4_q2_hi <= r_s3_q2_hi;
        r_s4_rem   <= n_st2[7:0];
        r_s4_q     <= {r_s3_q, n_st3[8], n_st2[8]};
        r_s4_nlow  <= r_s3_nlow[1:0];
        r_s4_d     <= r_s3_d;
        r_s4_s     <= r_s3_s;
        r_s4_ctl   <= r_s3_ctl;
    end

    // stage 5: last quotient bits, mode select
    logic [8:0] n_st1;
    logic [8:0] n_st0;
    logic [7:0] n_q_div;
    logic [8:0] n_sum9;
    logic [7:0] n_x;
    logic [7:0] r_s5_x;
    logic [7:0] r_s5_d;
    logic [7:0] r_s5_s;
    t_ctl       r_s5_ctl;

    assign n_st1   = div_step(r_s4_rem, r_s4_nlow[1], r_s4_s);
    assign n_st0   = div_step(n_st1[7:0], r_s4_nlow[0], r_s4_s);
    assign n_q_div = {r_s4_q, n_st1[8], n_st0[8]};
    assign n_sum9  = {1'b0, r_s4_d} + {1'b0, r_s4_s};

    always_comb begin
        unique case (r_s4_ctl.mode)
            MODE_ADD:       n_x = n_sum9[8] ? MAX8 : n_sum9[7:0];
            MODE_SUB:       n_x = (r_s4_d > r_s4_s) ? (r_s4_d - r_s4_s) : 8'd0;
            MODE_MUL:       n_x = r_s4_q_mul;
            MODE_DIV:       n_x = (r_s4_d >= r_s4_s) ? MAX8 : n_q_div;
            MODE_SCREEN:    n_x = MAX8 - r_s4_q_scr;
            MODE_OVERLAY:   n_x = (r_s4_d < HALF8) ? r_s4_q2_lo : (MAX8 - r_s4_q2_hi);
            MODE_DARKEN:    n_x = (r_s4_d < r_s4_s) ? r_s4_d : r_s4_s;
            MODE_LIGHTEN:   n_x = (r_s4_d > r_s4_s) ? r_s4_d : r_s4_s;
            MODE_HARDLIGHT: n_x = (r_s4_s < HALF8) ? r_s4_q2_lo : (MAX8 - r_s4_q2_hi);
            default:        n_x = r_s4_s;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_s5_x   <= n_x;
        r_s5_d   <= r_s4_d;
        r_s5_s   <= r_s4_s;
        r_s5_ctl <= r_s4_ctl;
    end

    // stage 6: weighted sum
    logic [15:0] r_s6_sum;
    logic [7:0]  r_s6_d;
    logic [7:0]  r_s6_s;
    t_ctl        r_s6_ctl;

    always_ff @(posedge i_clk) begin
        r_s6_sum <= 16'(r_s5_x) * 16'(r_s5_ctl.a)
                  + 16'(r_s5_d) * 16'(MAX8 - r_s5_ctl.a);
        r_s6_d   <= r_s5_d;
        r_s6_s   <= r_s5_s;
        r_s6_ctl <= r_s5_ctl;
    end

    // stage 7: normalize and pick pass-through cases
    logic [8:0] n_mix;
    logic [7:0] n_pix;
    logic [7:0] r_pix;

    assign n_mix = div255({1'b0, r_s6_sum});

    always_comb begin
        priority if (r_s6_ctl.pass_dst) begin
            n_pix = r_s6_d;
        end else if (r_s6_ctl.copy_src) begin
            n_pix = r_s6_s;
        end else begin
            n_pix = n_mix[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
    end

    assign o_pix = r_pix;

endmodule

[rtl/pbmc_alpha_lane.sv]
// Alpha channel: coverage accumulate, delay match and final select.
module pbmc_alpha_lane import pbmc_pkg::*; (
    input  logic       i_clk,
    input  logic [7:0] i_d,
    input  logic [7:0] i_s,
    input  t_ctl       i_ctl,
    output logic [7:0] o_alpha
);

    localparam int DLY = 3;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] d;
        logic [7:0] s;
        t_ctl       ctl;
    } t_apix;

    logic [15:0] r_s2_pa;
    logic [7:0]  r_s2_d;
    logic [7:0]  r_s2_s;
    t_ctl        r_s2_ctl;

    always_ff @(posedge i_clk) begin
        r_s2_pa  <= 16'(i_d) * 16'(MAX8 - i_ctl.a);
        r_s2_d   <= i_d;
        r_s2_s   <= i_s;
        r_s2_ctl <= i_ctl;
    end

    logic [8:0] n_qa;
    t_apix      n_s3;
    t_apix      r_s3;

    assign n_qa = div255({1'b0, r_s2_pa});

    always_comb begin
        n_s3.alpha = r_s2_ctl.a + n_qa[7:0];
        n_s3.d     = r_s2_d;
        n_s3.s     = r_s2_s;
        n_s3.ctl   = r_s2_ctl;
    end

    always_ff @(posedge i_clk) begin
        r_s3 <= n_s3;
    end

    // match the colour lanes' divider depth
    t_apix r_dly [DLY];

    always_ff @(posedge i_clk) begin
        r_dly[0] <= r_s3;
        for (int i = 1; i < DLY; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    logic [7:0] n_alpha;
    logic [7:0] r_alpha;

    always_comb begin
        priority if (r_dly[DLY-1].ctl.pass_dst) begin
            n_alpha = r_dly[DLY-1].d;
        end else if (r_dly[DLY-1].ctl.copy_src) begin
            n_alpha = r_dly[DLY-1].s;
        end else begin
            n_alpha = r_dly[DLY-1].alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        r_alpha <= n_alpha;
    end

    assign o_alpha = r_alpha;

endmodule

[rtl/pbmc_checker.sv]
// Port-level checker for the compositor, bound to the top level.
`include "pixel_blend_mode_compositor_top_defines.svh"

module pbmc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [7:0] i_dst_red,
    input logic [7:0] i_dst_green,
    input logic [7:0] i_dst_blue,
    input logic [7:0] i_dst_alpha,
    input logic [7:0] i_src_alpha,
    input logic       o_strobe,
    input logic [7:0] o_out_red,
    input logic [7:0] o_out_green,
    input logic [7:0] o_out_blue,
    input logic [7:0] o_out_alpha
);

    // every beat comes back after the fixed latency
    `PBMC_ASSERT_NEXT(a_beat_returns, start && !busy, ##6 o_strobe, "beat lost in pipeline")

    // no result without a beat taken for it
    `PBMC_ASSERT_AT(a_no_spurious, o_strobe, $past(start && !busy, 7), "result without beat")

    // transparent source leaves the destination untouched
    `PBMC_ASSERT_AT(a_zero_opacity, start && !busy && (i_src_alpha == 8'd0), ##7 ((o_out_red == $past(i_dst_red, 7)) && (o_out_green == $past(i_dst_green, 7)) && (o_out_blue == $past(i_dst_blue, 7)) && (o_out_alpha == $past(i_dst_alpha, 7))), "zero opacity changed destination")

endmodule

bind pixel_blend_mode_compositor_top pbmc_checker u_pbmc_checker (.*);

[test/tb_pixel_blend_mode_compositor_top.sv]
// Self-checking regression of the RGBA8 blend-mode compositor: predicted pixels vs strobed beats.
`timescale 1ns / 100ps

module tb_pixel_blend_mode_compositor_top import pbmc_pkg::*;;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_rgba;

    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 200;
    localparam int PHASE_COUNT  = 10;
    localparam int DRAIN_CYCLES = 10;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic [7:0]            i_dst_red;
    logic [7:0]            i_dst_green;
    logic [7:0]            i_dst_blue;
    logic [7:0]            i_dst_alpha;
    logic [7:0]            i_src_red;
    logic [7:0]            i_src_green;
    logic [7:0]            i_src_blue;
    logic [7:0]            i_src_alpha;
    logic                  o_strobe;
    logic [7:0]            o_out_red;
    logic [7:0]            o_out_green;
    logic [7:0]            o_out_blue;
    logic [7:0]            o_out_alpha;

    t_mode       cur_mode;
    logic [8:0]  cur_gain;
    t_rgba       composited_q[$];
    int unsigned mismatch_count;
    int unsigned stall_cycles;
    bit          idle_en;

    pixel_blend_mode_compositor_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_dst_red   (i_dst_red),
        .i_dst_green (i_dst_green),
        .i_dst_blue  (i_dst_blue),
        .i_dst_alpha (i_dst_alpha),
        .i_src_red   (i_src_red),
        .i_src_green (i_src_green),
        .i_src_blue  (i_src_blue),
        .i_src_alpha (i_src_alpha),
        .o_strobe    (o_strobe),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned mode_level(t_mode mode, int unsigned d, int unsigned s);
        int unsigned t;
        case (mode)
            MODE_ADD: begin
                t = d + s;
                return (t > 255) ? 255 : t;
            end
            MODE_SUB:      return (d > s) ? d - s : 0;
            MODE_MUL:      return (d * s) / 255;
            MODE_DIV: begin
                if (s == 0) return 255;
                t = (d * 255) / s;
                return (t > 255) ? 255 : t;
            end
            MODE_SCREEN:   return 255 - ((255 - d) * (255 - s)) / 255;
            MODE_OVERLAY:  return (d < 128) ? (2 * d * s) / 255
                                            : 255 - (2 * (255 - d) * (255 - s)) / 255;
            MODE_DARKEN:   return (d < s) ? d : s;
            MODE_LIGHTEN:  return (d > s) ? d : s;
            MODE_HARDLIGHT: return (s < 128) ? (2 * d * s) / 255
                                             : 255 - (2 * (255 - d) * (255 - s)) / 255;
            default:       return s;
        endcase
    endfunction

    function automatic t_rgba composite_pixel(t_rgba dst, t_rgba src, t_mode mode_reg,
                                              logic [8:0] gain);
        t_mode       mode;
        int unsigned a;
        int unsigned d[3];
        int unsigned s[3];
        int unsigned mixed[3];
        t_rgba       res;
        mode = (mode_reg > MODE_HARDLIGHT) ? MODE_ALPHA : mode_reg;
        a = (int'(src.alpha) * int'(gain)) >> 8;
        if (a > 255) a = 255;
        if (a == 0) return dst;
        if (mode == MODE_ALPHA && a == 255) return src;
        d = '{dst.red, dst.green, dst.blue};
        s = '{src.red, src.green, src.blue};
        for (int c = 0; c < 3; c++) begin
            mixed[c] = (mode_level(mode, d[c], s[c]) * a + d[c] * (255 - a)) / 255;
        end
        res.red   = 8'(mixed[0]);
        res.green = 8'(mixed[1]);
        res.blue  = 8'(mixed[2]);
        res.alpha = 8'(a + (int'(dst.alpha) * (255 - a)) / 255);
        return res;
    endfunction

    function automatic logic [7:0] random_level();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_rgba random_rgba();
        t_rgba p;
        p.red   = random_level();
        p.green = random_level();
        p.blue  = random_level();
        p.alpha = random_level();
        return p;
    endfunction

    function automatic t_rgba rgba(int r, int g, int b, int a);
        t_rgba p;
        p.red   = 8'(r);
        p.green = 8'(g);
        p.blue  = 8'(b);
        p.alpha = 8'(a);
        return p;
    endfunction

    task automatic send_pixel(input t_rgba dst, input t_rgba src);
        while (idle_en && $urandom_range(99) < 33) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_dst_red   <= dst.red;
        i_dst_green <= dst.green;
        i_dst_blue  <= dst.blue;
        i_dst_alpha <= dst.alpha;
        i_src_red   <= src.red;
        i_src_green <= src.green;
        i_src_blue  <= src.blue;
        i_src_alpha <= src.alpha;
        do @(posedge i_clk); while (busy !== 1'b0);
        composited_q = {composited_q, composite_pixel(dst, src, cur_mode, cur_gain)};
    endtask

    task automatic drain();
        start <= 1'b0;
        while (composited_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_BLEND_MODE) begin
            cur_mode = t_mode'(data[3:0]);
        end else if (idx == CFG_ALPHA_GAIN) begin
            cur_gain = data;
        end
    endtask

    task automatic set_config(input t_mode mode, input logic [8:0] gain);
        drain();
        cfg_write(CFG_BLEND_MODE, CFG_DATA_W'(mode));
        cfg_write(CFG_ALPHA_GAIN, gain);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic test_reset_defaults();
        send_pixel(rgba(10, 20, 30, 40), rgba(200, 100, 50, 255));
        send_pixel(rgba(10, 20, 30, 40), rgba(200, 100, 50, 100));
    endtask

    // one pixel per mode; channels straddle the 128 threshold and blue hits a zero source
    task automatic test_mode_sweep();
        for (int m = MODE_ALPHA; m <= MODE_HARDLIGHT; m++) begin
            set_config(t_mode'(m), 9'd256);
            send_pixel(rgba(127, 128, 255, 90), rgba(128, 127, 0, 200));
        end
    endtask

    task automatic test_special_cases();
        set_config(MODE_ALPHA, 9'd256);
        send_pixel(rgba(1, 2, 3, 4), rgba(250, 251, 252, 255));
        send_pixel(rgba(1, 2, 3, 4), rgba(250, 251, 252, 0));
        send_pixel(rgba(0, 0, 0, 0), rgba(0, 0, 0, 0));
        send_pixel(rgba(255, 255, 255, 255), rgba(255, 255, 255, 255));
        set_config(MODE_ADD, 9'h1FF);
        send_pixel(rgba(100, 200, 0, 30), rgba(100, 200, 0, 255));
        send_pixel(rgba(100, 200, 0, 30), rgba(50, 70, 90, 129));
        set_config(t_mode'(MODE_HARDLIGHT + 1), 9'd256);
        send_pixel(rgba(40, 50, 60, 70), rgba(200, 210, 220, 255));
        set_config(t_mode'(4'hF), 9'd200);
        send_pixel(rgba(40, 50, 60, 70), rgba(200, 210, 220, 180));
        set_config(MODE_DIV, 9'd256);
        send_pixel(rgba(255, 0, 77, 9), rgba(0, 0, 0, 255));
        set_config(MODE_SCREEN, 9'd0);
        send_pixel(rgba(12, 34, 56, 78), rgba(255, 255, 255, 255));
    endtask

    task automatic test_random();
        t_mode      mode;
        logic [8:0] gain;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin mode = MODE_ALPHA;     gain = 9'd256; end
                1: begin mode = MODE_HARDLIGHT; gain = 9'h1FF; end
                2: begin mode = MODE_OVERLAY;   gain = 9'd1;   end
                default: begin
                    if ($urandom_range(9) == 0) begin
                        mode = t_mode'($urandom_range(15, MODE_HARDLIGHT + 1));
                    end else begin
                        mode = t_mode'($urandom_range(MODE_HARDLIGHT, MODE_ALPHA));
                    end
                    case ($urandom_range(6))
                        0:       gain = 9'd0;
                        1:       gain = 9'd255;
                        2:       gain = 9'd256;
                        3:       gain = 9'd257;
                        4:       gain = 9'h1FF;
                        default: gain = 9'($urandom_range(511));
                    endcase
                end
            endcase
            set_config(mode, gain);
            idle_en = (phase != 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 6 && n == PHASE_ITEMS / 2) drain();
                send_pixel(random_rgba(), random_rgba());
            end
        end
        idle_en = 1'b1;
    endtask

    always @(posedge i_clk) begin : result_check
        t_rgba want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (composited_q.size() == 0) begin
                $error("result beat with no pixel pending");
                mismatch_count++;
            end else begin
                want = composited_q.pop_front();
                check_field("out_red",   want.red,   o_out_red);
                check_field("out_green", want.green, o_out_green);
                check_field("out_blue",  want.blue,  o_out_blue);
                check_field("out_alpha", want.alpha, o_out_alpha);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1 || i_cfg_we || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("pixel_blend_mode_compositor_top regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        mismatch_count = 0;
        stall_cycles   = 0;
        idle_en        = 1'b1;
        cur_mode       = MODE_ALPHA;
        cur_gain       = 9'd256;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_BLEND_MODE;
        i_cfg_data  <= '0;
        i_dst_red   <= '0;
        i_dst_green <= '0;
        i_dst_blue  <= '0;
        i_dst_alpha <= '0;
        i_src_red   <= '0;
        i_src_green <= '0;
        i_src_blue  <= '0;
        i_src_alpha <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_mode_sweep();
        test_special_cases();
        test_random();
        drain();

        if (composited_q.size() != 0) begin
            $error("%0d pixels never came out", composited_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("pixel_blend_mode_compositor_top regression: pass");
        end else begin
            $display("pixel_blend_mode_compositor_top regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/pbmc_pkg.sv
rtl/pbmc_lane.sv
rtl/pbmc_alpha_lane.sv
rtl/pixel_blend_mode_compositor_top.sv
rtl/pbmc_checker.sv
test/tb_pixel_blend_mode_compositor_top.sv
